// File: src/sha1_message_digest_macros.svh
// ----------------------------------------------------------------------------
// SHA-1 message digest: assertion macros
// Shorthand for the concurrent checks used in the digest block. The macros
// expect signals named clk and rst_n in the module that uses them.
// ----------------------------------------------------------------------------
`ifndef SHA1_MESSAGE_DIGEST_MACROS_SVH
`define SHA1_MESSAGE_DIGEST_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SMD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/smd_pkg.sv
// ----------------------------------------------------------------------------
// SHA-1 message digest package
// Constants and small helper functions of the SHA-1 compression.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package smd_pkg;

  localparam int unsigned CHAIN_WORDS = 5;
  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned ROUNDS      = 80;

  localparam logic [31:0] INIT_H [CHAIN_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_MARK = 8'h80;

  function automatic logic [31:0] rotl1(input logic [31:0] v);
    return {v[30:0], v[31]};
  endfunction

  function automatic logic [31:0] rotl5(input logic [31:0] v);
    return {v[26:0], v[31:27]};
  endfunction

  function automatic logic [31:0] rotl30(input logic [31:0] v);
    return {v[1:0], v[31:2]};
  endfunction

  // Round constant and round function by round number.
  function automatic logic [31:0] round_k(input logic [6:0] r);
    logic [31:0] k;
    if (r < 7'd20) begin
      k = K0;
    end else if (r < 7'd40) begin
      k = K1;
    end else if (r < 7'd60) begin
      k = K2;
    end else begin
      k = K3;
    end
    return k;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (r < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (r < 7'd40 || r >= 7'd60) begin
      f = b ^ c ^ d;
    end else begin
      f = (b & c) | (b & d) | (c & d);
    end
    return f;
  endfunction

endpackage

// File: src/sha1_message_digest.sv
// ----------------------------------------------------------------------------
// SHA-1 message digest
// Byte-serial SHA-1 engine with the message block and the chaining words held
// in small synchronous memories and one compression round per cycle.
// ----------------------------------------------------------------------------
// Usage: message bytes arrive on the in_ channel, one per beat. in_tuser set
// means in_tdata carries a message byte; in_tlast closes the message, with or
// without a byte of its own. A beat with neither flag does nothing.
// A byte that does not complete a 64-byte block is stored and the input stays
// ready. A byte that completes one is accepted and then the working variables
// are loaded from the chaining memory, the 80 rounds run in the single round
// unit and the result is added back into that memory; the input waits until
// that is done.
// The closing beat pads the block (a set-up step, then one memory write per
// remaining word), runs one or two compressions and then emits h0 to h4 on the
// out_ channel, each word read from the chaining memory, summed and then held,
// with out_tlast on h4. The input stays stalled until h4 has been taken; a
// stalled receiver simply holds the current word.
// After reset, and after each digest, the chaining words read as the initial
// values and the byte count is zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "sha1_message_digest_macros.svh"

module sha1_message_digest
  import smd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] byte_valid
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic        out_tlast   // final_word
);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_ROUND, S_UPD, S_PAD_START, S_PAD, S_OUT_RD, S_OUT_LD, S_OUT_WAIT
  } state_t;

  localparam logic [2:0] LAST_STEP = 3'(CHAIN_WORDS);
  localparam logic [2:0] LAST_WORD = 3'(CHAIN_WORDS - 1);
  localparam logic [6:0] LAST_RND  = 7'(ROUNDS - 1);
  localparam logic [3:0] LAST_BLKW = 4'(BLOCK_WORDS - 1);
  localparam logic [3:0] LEN_HI_W  = 4'(BLOCK_WORDS - 2);

  // Memories
  logic [31:0] blk_mem   [BLOCK_WORDS];
  logic [31:0] chain_mem [CHAIN_WORDS];
  logic [31:0] blk_q_r;
  logic [31:0] chain_q_r;

  // Control and payload registers
  state_t      state_r, state_nxt;
  logic [60:0] count_r, count_nxt;
  logic [31:0] wbuf_r, wbuf_nxt;
  logic [2:0]  step_r, step_nxt;
  logic [6:0]  round_r, round_nxt;
  logic [31:0] v_r  [CHAIN_WORDS];
  logic [31:0] v_nxt [CHAIN_WORDS];
  logic [31:0] sr_r  [BLOCK_WORDS];
  logic [31:0] sr_nxt [BLOCK_WORDS];
  logic [2:0]  chain_ra_q_r;
  logic        fresh_r, fresh_nxt;
  logic        end_pend_r, end_pend_nxt;
  logic        in_pad_r, in_pad_nxt;
  logic        len_blk_r, len_blk_nxt;
  logic        final_r, final_nxt;
  logic [3:0]  pad_idx_r, pad_idx_nxt;
  logic        pad_first_r, pad_first_nxt;
  logic [2:0]  out_idx_r, out_idx_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_data_r, out_data_nxt;
  logic        out_last_r, out_last_nxt;

  // Memory port controls
  logic        blk_we;
  logic [3:0]  blk_wa;
  logic [31:0] blk_wd;
  logic [3:0]  blk_ra;
  logic        chain_we;
  logic [2:0]  chain_ra;

  // Datapath
  logic [1:0]  pos;
  logic [4:0]  pos_sh;
  logic [31:0] word_new;
  logic [31:0] mark_word;
  logic [31:0] pad_word;
  logic [31:0] chain_val;
  logic [31:0] chain_sum;
  logic [31:0] w_cur;
  logic [31:0] t_sum;

  assign pos    = count_r[1:0];
  assign pos_sh = {pos, 3'b000};

  // Bytes sit big-endian in the word: the first byte of a word is its top byte.
  assign word_new  = (wbuf_r & ~(32'hFF000000 >> pos_sh)) | ({in_tdata, 24'h000000} >> pos_sh);
  assign mark_word = (wbuf_r & ~(32'hFFFFFFFF >> pos_sh)) | ({PAD_MARK, 24'h000000} >> pos_sh);

  always_comb begin
    if (pad_first_r) begin
      pad_word = mark_word;
    end else if (len_blk_r && pad_idx_r == LEN_HI_W) begin
      pad_word = count_r[60:29];
    end else if (len_blk_r && pad_idx_r == LAST_BLKW) begin
      pad_word = {count_r[28:0], 3'b000};
    end else begin
      pad_word = 32'h00000000;
    end
  end

  // The chaining words read as the initial values until a compression writes them.
  assign chain_val = fresh_r ? INIT_H[chain_ra_q_r] : chain_q_r;
  assign chain_sum = chain_val + v_r[chain_ra_q_r];

  assign w_cur = (round_r < 7'(BLOCK_WORDS)) ? blk_q_r
                 : rotl1(sr_r[13] ^ sr_r[8] ^ sr_r[2] ^ sr_r[0]);
  assign t_sum = rotl5(v_r[0]) + round_f(round_r, v_r[1], v_r[2], v_r[3]) + v_r[4]
                 + round_k(round_r) + w_cur;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    wbuf_nxt      = wbuf_r;
    step_nxt      = step_r;
    round_nxt     = round_r;
    v_nxt         = v_r;
    sr_nxt        = sr_r;
    fresh_nxt     = fresh_r;
    end_pend_nxt  = end_pend_r;
    in_pad_nxt    = in_pad_r;
    len_blk_nxt   = len_blk_r;
    final_nxt     = final_r;
    pad_idx_nxt   = pad_idx_r;
    pad_first_nxt = pad_first_r;
    out_idx_nxt   = out_idx_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    blk_we        = 1'b0;
    blk_wa        = count_r[5:2];
    blk_wd        = word_new;
    blk_ra        = 4'd0;
    chain_we      = 1'b0;
    chain_ra      = 3'd0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser) begin
            wbuf_nxt  = word_new;
            count_nxt = count_r + 61'd1;
            blk_we    = (pos == 2'd3);
            if (count_r[5:0] == 6'd63) begin
              state_nxt    = S_LOAD;
              step_nxt     = 3'd0;
              end_pend_nxt = in_tlast;
              in_pad_nxt   = 1'b0;
              final_nxt    = 1'b0;
            end else if (in_tlast) begin
              end_pend_nxt = 1'b1;
              state_nxt    = S_PAD_START;
            end
          end else if (in_tlast) begin
            end_pend_nxt = 1'b1;
            state_nxt    = S_PAD_START;
          end
        end
      end

      S_LOAD: begin
        chain_ra = (step_r < LAST_STEP) ? step_r : 3'd0;
        if (step_r != 3'd0) begin
          v_nxt[chain_ra_q_r] = chain_val;
        end
        if (step_r == LAST_STEP) begin
          state_nxt = S_ROUND;
          round_nxt = 7'd0;
          step_nxt  = 3'd0;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end

      S_ROUND: begin
        // Prefetch the next message word for the first sixteen rounds.
        blk_ra = round_r[3:0] + 4'd1;
        for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
          sr_nxt[i] = sr_r[i + 1];
        end
        sr_nxt[BLOCK_WORDS - 1] = w_cur;
        v_nxt[4] = v_r[3];
        v_nxt[3] = v_r[2];
        v_nxt[2] = rotl30(v_r[1]);
        v_nxt[1] = v_r[0];
        v_nxt[0] = t_sum;
        if (round_r == LAST_RND) begin
          round_nxt = 7'd0;
          if (final_r) begin
            state_nxt   = S_OUT_RD;
            out_idx_nxt = 3'd0;
          end else begin
            state_nxt = S_UPD;
            step_nxt  = 3'd0;
          end
        end else begin
          round_nxt = round_r + 7'd1;
        end
      end

      S_UPD: begin
        // Read one word ahead while the previous one is written back.
        chain_ra = (step_r < LAST_STEP) ? step_r : 3'd0;
        chain_we = (step_r != 3'd0);
        if (step_r == LAST_STEP) begin
          step_nxt  = 3'd0;
          fresh_nxt = 1'b0;
          if (!end_pend_r) begin
            state_nxt = S_IDLE;
          end else if (in_pad_r) begin
            state_nxt     = S_PAD;
            pad_idx_nxt   = 4'd0;
            pad_first_nxt = 1'b0;
            len_blk_nxt   = 1'b1;
          end else begin
            state_nxt = S_PAD_START;
          end
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end

      S_PAD_START: begin
        pad_idx_nxt   = count_r[5:2];
        pad_first_nxt = 1'b1;
        len_blk_nxt   = (count_r[5:3] != 3'b111);
        in_pad_nxt    = 1'b1;
        state_nxt     = S_PAD;
      end

      S_PAD: begin
        blk_we        = 1'b1;
        blk_wa        = pad_idx_r;
        blk_wd        = pad_word;
        pad_first_nxt = 1'b0;
        if (pad_idx_r == LAST_BLKW) begin
          state_nxt = S_LOAD;
          step_nxt  = 3'd0;
          final_nxt = len_blk_r;
        end else begin
          pad_idx_nxt = pad_idx_r + 4'd1;
        end
      end

      S_OUT_RD: begin
        chain_ra  = out_idx_r;
        state_nxt = S_OUT_LD;
      end

      S_OUT_LD: begin
        out_data_nxt  = chain_sum;
        out_last_nxt  = (out_idx_r == LAST_WORD);
        out_valid_nxt = 1'b1;
        state_nxt     = S_OUT_WAIT;
      end

      S_OUT_WAIT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          if (out_idx_r == LAST_WORD) begin
            state_nxt    = S_IDLE;
            fresh_nxt    = 1'b1;
            count_nxt    = 61'd0;
            end_pend_nxt = 1'b0;
            in_pad_nxt   = 1'b0;
            final_nxt    = 1'b0;
          end else begin
            out_idx_nxt = out_idx_r + 3'd1;
            state_nxt   = S_OUT_RD;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= 61'd0;
      step_r      <= 3'd0;
      round_r     <= 7'd0;
      fresh_r     <= 1'b1;
      end_pend_r  <= 1'b0;
      in_pad_r    <= 1'b0;
      len_blk_r   <= 1'b0;
      final_r     <= 1'b0;
      pad_idx_r   <= 4'd0;
      pad_first_r <= 1'b0;
      out_idx_r   <= 3'd0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      step_r      <= step_nxt;
      round_r     <= round_nxt;
      fresh_r     <= fresh_nxt;
      end_pend_r  <= end_pend_nxt;
      in_pad_r    <= in_pad_nxt;
      len_blk_r   <= len_blk_nxt;
      final_r     <= final_nxt;
      pad_idx_r   <= pad_idx_nxt;
      pad_first_r <= pad_first_nxt;
      out_idx_r   <= out_idx_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
    wbuf_r       <= wbuf_nxt;
    v_r          <= v_nxt;
    sr_r         <= sr_nxt;
    out_data_r   <= out_data_nxt;
    chain_ra_q_r <= chain_ra;
  end

  // Message block memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (blk_we) begin
      blk_mem[blk_wa] <= blk_wd;
    end
    blk_q_r <= blk_mem[blk_ra];
  end

  // Chaining memory: written at the word read in the previous cycle.
  always_ff @(posedge clk) begin
    if (chain_we) begin
      chain_mem[chain_ra_q_r] <= chain_sum;
    end
    chain_q_r <= chain_mem[chain_ra];
  end

  `SMD_ASSERT_NOW(a_no_overlap, in_tready, !out_tvalid, "input taken while a digest word is pending")
  `SMD_ASSERT_NEXT(a_digest_done, out_tvalid && out_tready && out_tlast, in_tready && fresh_r && count_r == 61'd0, "block not returned to its initial state after the digest")
  `SMD_ASSERT_NOW(a_round_range, state_r == S_ROUND, round_r <= LAST_RND, "round counter beyond the last round")
  `SMD_ASSERT_NEXT(a_chain_written, state_r == S_UPD && step_r == LAST_STEP, !fresh_r, "chaining words still marked initial after an update")

endmodule

// File: dv/sha1_message_digest_test.sv
// ----------------------------------------------------------------------------
// SHA-1 message digest testbench
// Drives messages into the byte stream and keeps an independent SHA-1 digest
// calculator in step with every accepted beat. Each digest word taken from the
// result stream is compared with the oldest pending word. A short table of
// directed beats comes first, then random messages of mixed lengths with
// random idling on both sides, one long receiver stall and a calm ending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha1_message_digest_test;
  import smd_pkg::*;

  localparam int NUM_DIRECTED  = 15;
  localparam int RANDOM_BEATS  = 65;
  localparam int MIN_MESSAGES  = 8;
  localparam int CALM_BEATS    = 20;
  localparam int HOLD_CYCLES   = 600;
  localparam int DRAIN_CYCLES  = 300;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct packed {
    logic [7:0]   data;
    logic         valid;
    logic         last;
    logic         typed;
    logic [159:0] digest_hex;  // h0 in the top bits
  } stim_row_t;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } digest_beat_t;

  localparam logic [159:0] EMPTY_DIGEST = 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709;
  localparam logic [159:0] ABC_DIGEST   = 160'ha9993e364706816aba3e25717850c26c9cd0d89d;

  localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},  // empty message straight after reset
    '{8'hFF, 1'b0, 1'b0, 1'b0, 160'd0},        // idle beat
    '{8'h5A, 1'b0, 1'b0, 1'b0, 160'd0},
    '{8'h61, 1'b1, 1'b0, 1'b0, 160'd0},
    '{8'h62, 1'b1, 1'b0, 1'b0, 160'd0},
    '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},    // last byte and end in one beat
    '{8'hFF, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},  // data must be ignored
    '{8'h00, 1'b1, 1'b1, 1'b0, 160'd0},
    '{8'hFF, 1'b1, 1'b1, 1'b0, 160'd0},
    '{8'h80, 1'b1, 1'b0, 1'b0, 160'd0},
    '{8'h7F, 1'b1, 1'b0, 1'b0, 160'd0},
    '{8'h00, 1'b0, 1'b0, 1'b0, 160'd0},
    '{8'h01, 1'b0, 1'b1, 1'b0, 160'd0},
    '{8'hFE, 1'b1, 1'b0, 1'b0, 160'd0},
    '{8'h00, 1'b0, 1'b1, 1'b0, 160'd0}
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] data_byte
  logic        in_tuser;   // [0] byte_valid
  logic        in_tlast;   // end_of_message
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [31:0] digest_word
  logic        out_tlast;  // final_word

  // Digest calculator state
  logic [31:0] chain_words [5];
  logic [7:0]  block_bytes [64];
  logic [60:0] message_len;
  logic [31:0] fresh_digest [5];

  digest_beat_t pending_digest_q [$];

  int  error_count;
  int  beats_sent;
  int  messages_closed;
  int  words_checked;
  int  cycle_count;
  bit  hold_req;
  bit  calm;

  sha1_message_digest u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic void compress_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, t;
    int r, s;
    for (r = 0; r < 16; r++) begin
      w[r] = {block_bytes[4*r], block_bytes[4*r+1], block_bytes[4*r+2], block_bytes[4*r+3]};
    end
    a = chain_words[0];
    b = chain_words[1];
    c = chain_words[2];
    d = chain_words[3];
    e = chain_words[4];
    for (r = 0; r < 80; r++) begin
      s = r % 16;
      if (r >= 16) begin
        t = w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16] ^ w[s];
        w[s] = {t[30:0], t[31]};
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K2;
      end else begin
        f = b ^ c ^ d;
        k = K3;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[s];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    chain_words[0] += a;
    chain_words[1] += b;
    chain_words[2] += c;
    chain_words[3] += d;
    chain_words[4] += e;
  endfunction

  // Advances the calculator by one accepted beat; returns 1 when the beat
  // closes a message, with the digest left in fresh_digest.
  function automatic bit absorb_beat(logic [7:0] data, logic valid, logic last);
    int fill;
    int i;
    logic [63:0] bit_len;
    if (valid) begin
      fill = int'(message_len[5:0]);
      block_bytes[fill] = data;
      message_len = message_len + 61'd1;
      if (fill == 63) compress_block();
    end
    if (!last) return 1'b0;
    fill = int'(message_len[5:0]);
    block_bytes[fill] = PAD_MARK;
    for (i = fill + 1; i < 64; i++) block_bytes[i] = 8'h00;
    // No room left for the length, so it goes into a block of its own.
    if (fill >= 56) begin
      compress_block();
      for (i = 0; i < 64; i++) block_bytes[i] = 8'h00;
    end
    bit_len = {message_len, 3'b000};
    for (i = 0; i < 8; i++) block_bytes[56 + i] = bit_len[63 - 8*i -: 8];
    compress_block();
    for (i = 0; i < 5; i++) begin
      fresh_digest[i] = chain_words[i];
      chain_words[i] = INIT_H[i];
    end
    message_len = '0;
    return 1'b1;
  endfunction

  // Offers one beat from the falling edge and returns at the falling edge
  // after it has been taken, with in_tvalid still high.
  task automatic offer_beat(stim_row_t row);
    digest_beat_t beat;
    int i;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = row.data;
    in_tuser  = row.valid;
    in_tlast  = row.last;
    do @(posedge clk); while (!in_tready);
    if (row.valid || row.last) beats_sent++;
    if (absorb_beat(row.data, row.valid, row.last)) begin
      messages_closed++;
      for (i = 0; i < 5; i++) begin
        beat.word = row.typed ? row.digest_hex[159 - 32*i -: 32] : fresh_digest[i];
        beat.last = (i == 4);
        pending_digest_q.push_back(beat);
      end
    end
    @(negedge clk);
  endtask

  task automatic wait_for_digests();
    in_tvalid = 1'b0;
    do @(negedge clk); while (pending_digest_q.size() != 0);
  endtask

  task automatic send_message(int len, bit end_on_byte);
    stim_row_t row;
    int i;
    row.typed = 1'b0;
    row.digest_hex = '0;
    for (i = 0; i < len; i++) begin
      // Now and then an idle beat with junk on the data lines.
      if ($urandom_range(0, 9) == 0) begin
        row.data  = 8'($urandom_range(0, 255));
        row.valid = 1'b0;
        row.last  = 1'b0;
        offer_beat(row);
      end
      row.data  = 8'($urandom_range(0, 255));
      row.valid = 1'b1;
      row.last  = end_on_byte && (i == len - 1);
      offer_beat(row);
    end
    if (!end_on_byte || len == 0) begin
      row.data  = 8'($urandom_range(0, 255));
      row.valid = 1'b0;
      row.last  = 1'b1;
      offer_beat(row);
    end
  endtask

  function automatic int pick_length();
    int r;
    int edges [6] = '{55, 56, 57, 63, 64, 65};
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 12);
    if (r < 95) return edges[$urandom_range(0, 5)];
    return $urandom_range(100, 130);
  endfunction

  // Result side: compare every taken word with the oldest pending one.
  always @(posedge clk) begin
    digest_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_digest_q.size() == 0) begin
        $display("%0t: unexpected digest beat, actual word %h last %b",
                 $time, out_tdata, out_tlast);
        error_count++;
      end else begin
        want = pending_digest_q.pop_front();
        words_checked++;
        if (out_tdata !== want.word) begin
          $display("%0t: digest word mismatch, expected %h actual %h",
                   $time, want.word, out_tdata);
          error_count++;
        end
        if (out_tlast !== want.last) begin
          $display("%0t: last flag mismatch, expected %b actual %b",
                   $time, want.last, out_tlast);
          error_count++;
        end
      end
    end
  end

  // Receiver back-pressure.
  initial begin
    int n;
    out_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_tready = 1'b0;
        hold_req = 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(negedge clk);
      end else if (calm) begin
        out_tready = 1'b1;
        @(negedge clk);
      end else if ($urandom_range(0, 2) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end else begin
        out_tready = 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int i;
    int random_base;
    int left;
    int len;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    in_tlast  = 1'b0;
    rst_n     = 1'b0;
    error_count = 0;
    beats_sent = 0;
    messages_closed = 0;
    words_checked = 0;
    cycle_count = 0;
    hold_req = 1'b0;
    calm = 1'b0;
    message_len = '0;
    for (i = 0; i < 5; i++) chain_words[i] = INIT_H[i];
    for (i = 0; i < 64; i++) block_bytes[i] = 8'h00;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (i = 0; i < NUM_DIRECTED; i++) offer_beat(DIRECTED_ROWS[i]);
    wait_for_digests();

    // A full block whose last byte closes the message goes in; the receiver then
    // stalls while the digest is worked out, and the next message waits at the input.
    send_message(64, 1'b1);
    hold_req = 1'b1;
    send_message(8, 1'b0);
    wait_for_digests();

    random_base = beats_sent;
    while (beats_sent - random_base < RANDOM_BEATS || messages_closed < MIN_MESSAGES) begin
      left = RANDOM_BEATS - (beats_sent - random_base);
      if (left <= CALM_BEATS) calm = 1'b1;
      len = pick_length();
      if (len > left) len = (left > 0) ? left : 0;
      send_message(len, 1'($urandom_range(0, 1)));
    end

    in_tvalid = 1'b0;
    while (pending_digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_digest_q.size() != 0) begin
      $display("%0t: %0d digest words never arrived", $time, pending_digest_q.size());
      error_count++;
    end

    $display("Sent %0d message beats forming %0d messages; checked %0d digest words.",
             beats_sent, messages_closed, words_checked);
    $display("Covered empty, short and block-edge messages, idle beats and a long output stall.");
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
